### design/ssc_pkg.sv
// Shared types and constants for the shutter sensor timing capture unit.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package ssc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int TIME_BITS   = 32;
    localparam int CAP_COUNT   = 6;

    localparam logic [SAMPLE_BITS-1:0] LIGHT_THRESHOLD_RESET = SAMPLE_BITS'(200);

    // APB map: one 32-bit register per word
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [0:0] REG_LIGHT_THRESHOLD = 1'b0;

    // capture slots, in rule order
    localparam int CAP_FIRST_ON   = 0;
    localparam int CAP_MIDDLE_ON  = 1;
    localparam int CAP_LAST_ON    = 2;
    localparam int CAP_FIRST_OFF  = 3;
    localparam int CAP_MIDDLE_OFF = 4;
    localparam int CAP_LAST_OFF   = 5;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [TIME_BITS-1:0]   t_time;
    typedef logic [CAP_COUNT-1:0]   t_flags;

    // sample after the threshold compare
    typedef struct packed {
        t_time      time_us;
        logic       lit_first;
        logic       lit_middle;
        logic       lit_last;
    } t_sense;

    typedef struct packed {
        logic       indicator_lit;
        logic       measure_done;
        t_time      middle_span_us;
        t_time      opening_us;
        t_time      closing_us;
    } t_result;

endpackage

### design/ssc_apb_regs.sv
// APB configuration register block: holds the light threshold.
// Uses ssc_pkg.
`timescale 1ns / 1ps

module ssc_apb_regs (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ssc_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [ssc_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [ssc_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                  pready,
    output ssc_pkg::t_sample                      o_light_threshold
);

    ssc_pkg::t_sample r_threshold;
    ssc_pkg::t_sample n_threshold;
    logic             w_sel_thr;

    // word index is the top address bit; byte offsets inside a word alias
    assign w_sel_thr = (paddr[ssc_pkg::APB_ADDR_BITS-1] == ssc_pkg::REG_LIGHT_THRESHOLD);

    always_comb begin
        n_threshold = r_threshold;
        if (psel && penable && pwrite && w_sel_thr) begin
            n_threshold = pwdata[ssc_pkg::SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ssc_pkg::LIGHT_THRESHOLD_RESET;
        end else begin
            r_threshold <= n_threshold;
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_thr) begin
            prdata = ssc_pkg::APB_DATA_BITS'(r_threshold);
        end
    end

    assign pready            = 1'b1;
    assign o_light_threshold = r_threshold;

endmodule

### design/ssc_sense_stage.sv
// Input stage: compares the three sensor levels with the threshold and
// registers the timestamp and lit bits. Uses ssc_pkg.
`timescale 1ns / 1ps

module ssc_sense_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ssc_pkg::t_time    i_time_us,
    input  ssc_pkg::t_sample  i_level_first,
    input  ssc_pkg::t_sample  i_level_middle,
    input  ssc_pkg::t_sample  i_level_last,
    input  ssc_pkg::t_sample  i_light_threshold,
    input  logic              i_advance,
    output logic              o_valid,
    output ssc_pkg::t_sense   o_sense
);

    logic            r_valid;
    logic            n_valid;
    ssc_pkg::t_sense r_sense;
    logic            w_take;

    assign o_in_stall = r_valid && !i_advance;
    assign w_take     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_sense.time_us    <= i_time_us;
            r_sense.lit_first  <= (i_level_first  >= i_light_threshold);
            r_sense.lit_middle <= (i_level_middle >= i_light_threshold);
            r_sense.lit_last   <= (i_level_last   >= i_light_threshold);
        end
    end

    assign o_valid = r_valid;
    assign o_sense = r_sense;

endmodule

### design/ssc_capture_core.sv
// Capture rules, capture state and result register.
// Uses ssc_pkg.
`timescale 1ns / 1ps

module ssc_capture_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ssc_pkg::t_sense   i_sense,
    input  logic              i_out_stall,
    output logic              o_advance,
    output logic              o_out_valid,
    output ssc_pkg::t_result  o_result
);

    ssc_pkg::t_flags  r_flags;
    ssc_pkg::t_flags  n_flags;
    ssc_pkg::t_time   r_times [ssc_pkg::CAP_COUNT];
    ssc_pkg::t_time   w_eff   [ssc_pkg::CAP_COUNT];
    ssc_pkg::t_flags  w_take;
    ssc_pkg::t_flags  w_have;
    logic             r_out_valid;
    logic             n_out_valid;
    ssc_pkg::t_result r_result;
    ssc_pkg::t_result w_result;
    logic             w_fire;

    assign o_advance = !r_out_valid || !i_out_stall;
    assign w_fire    = i_valid && o_advance;

    // rules in order; each sees the captures made by the ones above it
    always_comb begin
        w_take = '0;
        w_have = r_flags;
        w_take[ssc_pkg::CAP_FIRST_ON] = !w_have[ssc_pkg::CAP_FIRST_ON] && i_sense.lit_first;
        w_have[ssc_pkg::CAP_FIRST_ON] = w_have[ssc_pkg::CAP_FIRST_ON]
                                        || w_take[ssc_pkg::CAP_FIRST_ON];
        w_take[ssc_pkg::CAP_MIDDLE_ON] = w_have[ssc_pkg::CAP_FIRST_ON]
                                         && !w_have[ssc_pkg::CAP_MIDDLE_ON]
                                         && i_sense.lit_middle;
        w_have[ssc_pkg::CAP_MIDDLE_ON] = w_have[ssc_pkg::CAP_MIDDLE_ON]
                                         || w_take[ssc_pkg::CAP_MIDDLE_ON];
        w_take[ssc_pkg::CAP_LAST_ON] = w_have[ssc_pkg::CAP_MIDDLE_ON]
                                       && !w_have[ssc_pkg::CAP_LAST_ON]
                                       && i_sense.lit_last;
        w_have[ssc_pkg::CAP_LAST_ON] = w_have[ssc_pkg::CAP_LAST_ON]
                                       || w_take[ssc_pkg::CAP_LAST_ON];
        w_take[ssc_pkg::CAP_FIRST_OFF] = w_have[ssc_pkg::CAP_FIRST_ON]
                                         && !w_have[ssc_pkg::CAP_FIRST_OFF]
                                         && !i_sense.lit_first;
        w_have[ssc_pkg::CAP_FIRST_OFF] = w_have[ssc_pkg::CAP_FIRST_OFF]
                                         || w_take[ssc_pkg::CAP_FIRST_OFF];
        w_take[ssc_pkg::CAP_MIDDLE_OFF] = w_have[ssc_pkg::CAP_FIRST_OFF]
                                          && w_have[ssc_pkg::CAP_MIDDLE_ON]
                                          && !w_have[ssc_pkg::CAP_MIDDLE_OFF]
                                          && !i_sense.lit_middle;
        w_have[ssc_pkg::CAP_MIDDLE_OFF] = w_have[ssc_pkg::CAP_MIDDLE_OFF]
                                          || w_take[ssc_pkg::CAP_MIDDLE_OFF];
        w_take[ssc_pkg::CAP_LAST_OFF] = w_have[ssc_pkg::CAP_MIDDLE_OFF]
                                        && w_have[ssc_pkg::CAP_LAST_ON]
                                        && !w_have[ssc_pkg::CAP_LAST_OFF]
                                        && !i_sense.lit_last;
        w_have[ssc_pkg::CAP_LAST_OFF] = w_have[ssc_pkg::CAP_LAST_OFF]
                                        || w_take[ssc_pkg::CAP_LAST_OFF];
    end

    // times as they stand after this sample's captures
    always_comb begin
        for (int i = 0; i < ssc_pkg::CAP_COUNT; i++) begin
            w_eff[i] = w_take[i] ? i_sense.time_us : r_times[i];
        end
    end

    always_comb begin
        w_result.indicator_lit  = w_have[ssc_pkg::CAP_FIRST_ON];
        w_result.measure_done   = w_take[ssc_pkg::CAP_LAST_OFF];
        w_result.middle_span_us = '0;
        w_result.opening_us     = '0;
        w_result.closing_us     = '0;
        if (w_take[ssc_pkg::CAP_LAST_OFF]) begin
            w_result.middle_span_us = w_eff[ssc_pkg::CAP_MIDDLE_OFF]
                                      - w_eff[ssc_pkg::CAP_MIDDLE_ON];
            w_result.opening_us  = w_eff[ssc_pkg::CAP_LAST_ON]
                                   - w_eff[ssc_pkg::CAP_FIRST_ON];
            w_result.closing_us  = w_eff[ssc_pkg::CAP_LAST_OFF]
                                   - w_eff[ssc_pkg::CAP_FIRST_OFF];
        end
    end

    // completing sample clears the measurement; times are gated by flags
    always_comb begin
        n_flags = r_flags;
        if (w_fire) begin
            n_flags = w_take[ssc_pkg::CAP_LAST_OFF] ? '0 : w_have;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_flags     <= n_flags;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= w_result;
            for (int i = 0; i < ssc_pkg::CAP_COUNT; i++) begin
                if (w_take[i]) begin
                    r_times[i] <= i_sense.time_us;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

### design/shutter_sensor_timing_capture_unit.sv
// Top level of the shutter sensor timing capture unit.
// Instantiates ssc_apb_regs, ssc_sense_stage and ssc_capture_core; uses ssc_pkg.
`timescale 1ns / 1ps

// Takes one sensor sample request per clock while o_in_stall is low and returns
// one result request per sample, in order, through the input and result registers.
// The input register (threshold compares) and the result register (capture
// rules, state update and the three 32-bit differences) form a two-stage
// pipeline; the capture state is updated as each result is registered, so
// consecutive samples see each other's captures with no gap. The light
// threshold is written over APB at byte address 0 (resets to 200) and must
// only be changed while no request is in flight.

module shutter_sensor_timing_capture_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ssc_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [ssc_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [ssc_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                  pready,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [ssc_pkg::TIME_BITS-1:0]         i_time_us,
    input  logic [ssc_pkg::SAMPLE_BITS-1:0]       i_level_first,
    input  logic [ssc_pkg::SAMPLE_BITS-1:0]       i_level_middle,
    input  logic [ssc_pkg::SAMPLE_BITS-1:0]       i_level_last,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_indicator_lit,
    output logic                                  o_measure_done,
    output logic [ssc_pkg::TIME_BITS-1:0]         o_middle_span_us,
    output logic [ssc_pkg::TIME_BITS-1:0]         o_opening_us,
    output logic [ssc_pkg::TIME_BITS-1:0]         o_closing_us
);

    ssc_pkg::t_sample w_threshold;
    ssc_pkg::t_sense  w_sense;
    ssc_pkg::t_result w_result;
    logic             w_sense_valid;
    logic             w_advance;

    ssc_apb_regs u_regs (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_light_threshold (w_threshold)
    );

    ssc_sense_stage u_sense (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_time_us         (i_time_us),
        .i_level_first     (i_level_first),
        .i_level_middle    (i_level_middle),
        .i_level_last      (i_level_last),
        .i_light_threshold (w_threshold),
        .i_advance         (w_advance),
        .o_valid           (w_sense_valid),
        .o_sense           (w_sense)
    );

    ssc_capture_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_sense_valid),
        .i_sense     (w_sense),
        .i_out_stall (i_out_stall),
        .o_advance   (w_advance),
        .o_out_valid (o_out_valid),
        .o_result    (w_result)
    );

    assign o_indicator_lit  = w_result.indicator_lit;
    assign o_measure_done   = w_result.measure_done;
    assign o_middle_span_us = w_result.middle_span_us;
    assign o_opening_us     = w_result.opening_us;
    assign o_closing_us     = w_result.closing_us;

endmodule

### test/tb_shutter_sensor_timing_capture_unit.sv
// Self-checking testbench for shutter_sensor_timing_capture_unit: random sensor
// sweeps and noise with random idling, checked against an in-bench capture predictor.
// Depends on ssc_pkg and the design top level; needs nothing else.
`timescale 1ns / 1ps

module tb_shutter_sensor_timing_capture_unit;
    import ssc_pkg::*;

    localparam int REG_UNMAPPED = 1;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_THRESHOLD =
        APB_ADDR_BITS'(4 * REG_LIGHT_THRESHOLD);
    localparam logic [APB_ADDR_BITS-1:0] ADDR_UNMAPPED = APB_ADDR_BITS'(4 * REG_UNMAPPED);
    localparam logic APB_WRITE = 1'b1;
    localparam logic APB_READ  = 1'b0;
    localparam t_sample LEVEL_MAX = '1;

    typedef struct {
        t_time   time_us;
        t_sample first;
        t_sample middle;
        t_sample last;
    } sensor_sample_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    t_time                    i_time_us = '0;
    t_sample                  i_level_first = '0;
    t_sample                  i_level_middle = '0;
    t_sample                  i_level_last = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_indicator_lit;
    logic                     o_measure_done;
    t_time                    o_middle_span_us;
    t_time                    o_opening_us;
    t_time                    o_closing_us;

    shutter_sensor_timing_capture_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_time_us       (i_time_us),
        .i_level_first   (i_level_first),
        .i_level_middle  (i_level_middle),
        .i_level_last    (i_level_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_indicator_lit (o_indicator_lit),
        .o_measure_done  (o_measure_done),
        .o_middle_span_us(o_middle_span_us),
        .o_opening_us    (o_opening_us),
        .o_closing_us    (o_closing_us)
    );

    // predictor state
    t_sample light_thr = LIGHT_THRESHOLD_RESET;
    t_time   cap_time [CAP_COUNT];
    t_flags  cap_flags = '0;

    sensor_sample_t sample_q[$];
    sensor_sample_t cur_sample;
    t_result        result_q[$];
    int             queued_count = 0;
    int             taken_count = 0;
    int             mismatches = 0;
    logic           req_taken = 1'b0;
    int             in_gap = 0;
    int             in_calm = 0;
    int             stall_left = 0;
    int             out_calm = 0;
    t_time          clock_us = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("shutter_sensor_timing_capture_unit regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 30)
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    endtask

    function automatic void mark_capture(input int slot, input t_time now);
        cap_time[slot] = now;
        cap_flags[slot] = 1'b1;
    endfunction

    // apply the six capture rules in order; later rules see earlier captures
    function automatic t_result capture_step(input sensor_sample_t s);
        t_result r;
        logic lit_f, lit_m, lit_l, done;
        lit_f = s.first >= light_thr;
        lit_m = s.middle >= light_thr;
        lit_l = s.last >= light_thr;
        done = 1'b0;
        if (!cap_flags[CAP_FIRST_ON] && lit_f)
            mark_capture(CAP_FIRST_ON, s.time_us);
        if (cap_flags[CAP_FIRST_ON] && !cap_flags[CAP_MIDDLE_ON] && lit_m)
            mark_capture(CAP_MIDDLE_ON, s.time_us);
        if (cap_flags[CAP_MIDDLE_ON] && !cap_flags[CAP_LAST_ON] && lit_l)
            mark_capture(CAP_LAST_ON, s.time_us);
        if (cap_flags[CAP_FIRST_ON] && !cap_flags[CAP_FIRST_OFF] && !lit_f)
            mark_capture(CAP_FIRST_OFF, s.time_us);
        if (cap_flags[CAP_FIRST_OFF] && cap_flags[CAP_MIDDLE_ON] &&
            !cap_flags[CAP_MIDDLE_OFF] && !lit_m)
            mark_capture(CAP_MIDDLE_OFF, s.time_us);
        if (cap_flags[CAP_MIDDLE_OFF] && cap_flags[CAP_LAST_ON] &&
            !cap_flags[CAP_LAST_OFF] && !lit_l) begin
            mark_capture(CAP_LAST_OFF, s.time_us);
            done = 1'b1;
        end
        r = '0;
        r.indicator_lit = cap_flags[CAP_FIRST_ON];
        r.measure_done = done;
        if (done) begin
            r.middle_span_us = cap_time[CAP_MIDDLE_OFF] - cap_time[CAP_MIDDLE_ON];
            r.opening_us  = cap_time[CAP_LAST_ON] - cap_time[CAP_FIRST_ON];
            r.closing_us  = cap_time[CAP_LAST_OFF] - cap_time[CAP_FIRST_OFF];
            for (int k = 0; k < CAP_COUNT; k++)
                cap_time[k] = '0;
            cap_flags = '0;
        end
        return r;
    endfunction

    // mostly no gap, some short, a few long, and now and then a long calm run
    function automatic int gap_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_sample(input t_time t, input t_sample a,
                                         input t_sample b, input t_sample c);
        sensor_sample_t s;
        s.time_us = t;
        s.first = a;
        s.middle = b;
        s.last = c;
        sample_q.push_back(s);
        queued_count++;
    endfunction

    function automatic t_sample lit_level();
        if ($urandom_range(0, 3) == 0) return light_thr;
        return t_sample'($urandom_range(light_thr, LEVEL_MAX));
    endfunction

    function automatic t_sample dark_level();
        if (light_thr == 0) return '0;
        if ($urandom_range(0, 3) == 0) return light_thr - 1'b1;
        return t_sample'($urandom_range(0, light_thr - 1));
    endfunction

    function automatic t_time time_step();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return $urandom;
        return $urandom_range(1, 5000);
    endfunction

    // one shutter pass: sensors light up and go dark in order, with rare flips
    function automatic void queue_sweep();
        int on_at [3];
        int off_at [3];
        int len;
        logic lit;
        t_sample lv [3];
        on_at[0] = $urandom_range(0, 2);
        on_at[1] = on_at[0] + $urandom_range(0, 2);
        on_at[2] = on_at[1] + $urandom_range(0, 2);
        off_at[0] = on_at[0] + $urandom_range(1, 3);
        off_at[1] = ((off_at[0] > on_at[1]) ? off_at[0] : on_at[1] + 1) + $urandom_range(0, 2);
        off_at[2] = ((off_at[1] > on_at[2]) ? off_at[1] : on_at[2] + 1) + $urandom_range(0, 2);
        len = off_at[2] + 1 + $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0)
            clock_us = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        for (int k = 0; k < len; k++) begin
            for (int j = 0; j < 3; j++) begin
                lit = (k >= on_at[j]) && (k < off_at[j]);
                if ($urandom_range(0, 24) == 0) lit = !lit;
                lv[j] = lit ? lit_level() : dark_level();
            end
            queue_sample(clock_us, lv[0], lv[1], lv[2]);
            clock_us += time_step();
        end
    endfunction

    function automatic void queue_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            queue_sample(clock_us, t_sample'($urandom_range(0, LEVEL_MAX)),
                         t_sample'($urandom_range(0, LEVEL_MAX)),
                         t_sample'($urandom_range(0, LEVEL_MAX)));
            clock_us += time_step();
        end
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (taken_count != queued_count || result_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_BITS-1:0] addr,
                              input logic [APB_DATA_BITS-1:0] wdata,
                              output logic [APB_DATA_BITS-1:0] rdata);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_threshold();
        logic [APB_DATA_BITS-1:0] rd;
        apb_access(APB_READ, ADDR_THRESHOLD, '0, rd);
        if (rd != APB_DATA_BITS'(light_thr))
            report_mismatch("threshold readback", rd, APB_DATA_BITS'(light_thr));
    endtask

    // upper bits of the write data are junk and must be dropped
    task automatic set_threshold(input t_sample value);
        logic [APB_DATA_BITS-1:0] wd, rd;
        wd = $urandom;
        wd[SAMPLE_BITS-1:0] = value;
        apb_access(APB_WRITE, ADDR_THRESHOLD, wd, rd);
        light_thr = value;
        check_threshold();
    endtask

    task automatic run_traffic(input int n_items);
        int start;
        logic paused;
        start = queued_count;
        paused = 1'b0;
        while (queued_count - start < n_items) begin
            if ($urandom_range(0, 4) == 0)
                queue_noise();
            else
                queue_sweep();
            // hold the sender once until everything in flight has come back
            if (!paused && queued_count - start >= n_items / 2) begin
                wait_idle();
                paused = 1'b1;
            end
        end
        wait_idle();
    endtask

    always @(negedge i_clk) begin : sample_driver
        sensor_sample_t s;
        if (i_rst_n && !(i_in_valid && !req_taken)) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                s = sample_q.pop_front();
                cur_sample <= s;
                i_time_us <= s.time_us;
                i_level_first <= s.first;
                i_level_middle <= s.middle;
                i_level_last <= s.last;
                i_in_valid <= 1'b1;
                in_gap = gap_len(in_calm);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : result_stall
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 2) == 0) stall_left = gap_len(out_calm);
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result want;
        req_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    report_mismatch("result with no request pending",
                                    32'(o_measure_done), 32'd0);
                end else begin
                    want = result_q.pop_front();
                    if (o_indicator_lit !== want.indicator_lit)
                        report_mismatch("indicator_lit", 32'(o_indicator_lit),
                                        32'(want.indicator_lit));
                    if (o_measure_done !== want.measure_done)
                        report_mismatch("measure_done", 32'(o_measure_done),
                                        32'(want.measure_done));
                    if (o_middle_span_us !== want.middle_span_us)
                        report_mismatch("middle_span_us", o_middle_span_us,
                                        want.middle_span_us);
                    if (o_opening_us !== want.opening_us)
                        report_mismatch("opening_us", o_opening_us, want.opening_us);
                    if (o_closing_us !== want.closing_us)
                        report_mismatch("closing_us", o_closing_us, want.closing_us);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                result_q.push_back(capture_step(cur_sample));
                taken_count++;
            end
        end
    end

    initial begin : stimulus
        logic [APB_DATA_BITS-1:0] rd;
        for (int k = 0; k < CAP_COUNT; k++)
            cap_time[k] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset threshold
        queue_sample(32'h0, 12'h000, 12'hFFF, 12'hFFF);    // later sensors lit alone
        queue_sample(32'h0, 12'd200, 12'd200, 12'd200);    // all on at time zero, at threshold
        queue_sample(32'h5, 12'd199, 12'd199, 12'd199);    // all off at once: done
        // pass across the timestamp wrap
        queue_sample(32'hFFFF_FFF0, 12'hFFF, 12'h000, 12'h000);
        queue_sample(32'hFFFF_FFF8, 12'hFFF, 12'hFFF, 12'h000);
        queue_sample(32'hFFFF_FFFE, 12'h000, 12'hFFF, 12'h000);
        queue_sample(32'h0000_0003, 12'h000, 12'hFFF, 12'hFFF);
        queue_sample(32'h0000_0006, 12'h000, 12'hFFF, 12'h000);  // last dark too early
        queue_sample(32'h0000_0009, 12'h000, 12'h000, 12'hFFF);
        queue_sample(32'h0000_0010, 12'h000, 12'h000, 12'h000);
        // first goes dark before middle lights
        queue_sample(32'h7FFF_FFFF, 12'hFFF, 12'h000, 12'h000);
        queue_sample(32'h8000_0000, 12'h000, 12'h000, 12'h000);
        queue_sample(32'h8000_0001, 12'h000, 12'hFFF, 12'hFFF);
        queue_sample(32'hFFFF_FFFF, 12'h000, 12'h000, 12'h000);
        queue_sample(32'h1234_5678, 12'hFFF, 12'h7FF, 12'h800);
        wait_idle();

        // write to an unmapped register must leave the threshold alone
        apb_access(APB_WRITE, ADDR_UNMAPPED, $urandom, rd);
        check_threshold();

        clock_us = $urandom;
        set_threshold(LEVEL_MAX);
        run_traffic(220);
        set_threshold('0);
        run_traffic(40);
        set_threshold(t_sample'(1));
        run_traffic(250);
        set_threshold(LEVEL_MAX - 1'b1);
        run_traffic(200);
        set_threshold(t_sample'($urandom_range(2, LEVEL_MAX - 2)));
        run_traffic(320);
        set_threshold(LIGHT_THRESHOLD_RESET);
        run_traffic(300);

        repeat (10) @(negedge i_clk);
        if (mismatches == 0)
            $display("shutter_sensor_timing_capture_unit regression: pass");
        else
            $display("shutter_sensor_timing_capture_unit regression: fail");
        $finish;
    end

endmodule
